// ===== design/fbfl_pkg.sv =====
// Package for the fixed block free-list allocator.
// Holds beat structs, operation and status codes, FSM states and register indexes.
// No dependencies.
package fbfl_pkg;

    localparam int COUNT_W     = 9;
    localparam int BSIZE_W     = 16;
    localparam int STRIDE_W    = 17;
    localparam int OFFSET_W    = 24;
    localparam int CFG_DATA_W  = 16;

    localparam logic [BSIZE_W-1:0] BSIZE_RST      = 16'd8;
    localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 9'd256;

    localparam logic REG_BSIZE      = 1'b0;
    localparam logic REG_SLOT_COUNT = 1'b1;

    typedef enum logic [1:0] {
        FUNC_INIT    = 2'd0,
        FUNC_ALLOC   = 2'd1,
        FUNC_FREE    = 2'd2,
        FUNC_RELEASE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_INIT,
        S_FIN
    } state_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] slot_index;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [7:0]           granted_slot;
        logic [OFFSET_W-1:0]  byte_offset;
        logic [COUNT_W-1:0]   free_slots;
    } rsp_t;

endpackage

// ===== design/fixed_block_free_list_allocator.sv =====
// Fixed-size block pool allocator with a LIFO free list in a link memory.
// Alloc, free, release, rejected init: request and result registered, one at a time.
// Valid init: S_INIT threads slot_count links, one per cycle, through the
// single write port; the stride is a reciprocal multiply overlapped with the threading.
// Reset (async, rst_n low): empty pool, head none, counts and stride zero; the link
// memory is not cleared and holds garbage until init or free writes it.
module fixed_block_free_list_allocator #(
    parameter int NUM_SLOTS   = 256,
    parameter int ALIGN_BYTES = 16,
    parameter int LINK_BYTES  = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  fbfl_pkg::req_t                     in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output fbfl_pkg::rsp_t                     out_data,
    input  logic                               cfg_we,
    input  logic                               cfg_addr,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LW = $clog2(NUM_SLOTS + 1);
    localparam int XW = (LW > fbfl_pkg::COUNT_W) ? LW : fbfl_pkg::COUNT_W;
    localparam int MW = fbfl_pkg::STRIDE_W + 8;
    localparam int PW = (LW + fbfl_pkg::STRIDE_W > fbfl_pkg::OFFSET_W) ?
                        (LW + fbfl_pkg::STRIDE_W) : fbfl_pkg::OFFSET_W;
    localparam logic [LW-1:0] NONE_SLOT = LW'(NUM_SLOTS);

    localparam int BW = fbfl_pkg::BSIZE_W;
    localparam int CW = fbfl_pkg::COUNT_W;
    localparam int SW = fbfl_pkg::STRIDE_W;
    localparam int RS = SW + 7;
    localparam int QW = SW + RS + 1;
    localparam int RECIP_I = ((1 << RS) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam logic [RS:0] RECIP = (RS + 1)'(RECIP_I);

    logic [LW-1:0] link_mem [NUM_SLOTS];
    logic [LW-1:0] link_rd_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;

    fbfl_pkg::state_t state_reg, state_next;
    fbfl_pkg::req_t   req_reg;
    fbfl_pkg::rsp_t   out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic [BW-1:0] blk_size_reg;
    logic [CW-1:0] slot_cnt_reg;

    logic [LW-1:0] head_reg, head_next;
    logic [CW-1:0] free_reg, free_next;
    logic [CW-1:0] active_reg, active_next;
    logic [SW-1:0] stride_reg, stride_next;

    logic [AW-1:0] init_idx_reg, init_idx_next;
    logic          links_done_reg, links_done_next;
    logic [SW-1:0] div_dvd_reg, div_dvd_next;
    logic [SW-1:0] div_q_reg, div_q_next;

    logic          out_free;
    logic          init_bad;
    logic          free_bad;
    logic          list_empty;
    logic [BW-1:0] stride_base;
    logic [QW-1:0] div_prod;
    logic [MW-1:0] stride_mult;
    logic [PW-1:0] offset_prod;
    logic [XW-1:0] init_succ;
    logic          init_last;

    assign in_ready  = (state_reg == fbfl_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign init_bad    = (blk_size_reg == '0) || (slot_cnt_reg == '0) ||
                         (XW'(slot_cnt_reg) > XW'(NUM_SLOTS));
    assign free_bad    = ({1'b0, req_reg.slot_index} >= CW'(active_reg));
    assign list_empty  = (head_reg >= NONE_SLOT);
    assign stride_base = (blk_size_reg < BW'(LINK_BYTES)) ? BW'(LINK_BYTES) : blk_size_reg;
    assign div_prod    = QW'(div_dvd_reg) * QW'(RECIP);
    assign stride_mult = MW'(div_q_reg) * MW'(ALIGN_BYTES);
    assign offset_prod = PW'(head_reg) * PW'(stride_reg);
    assign init_succ   = XW'(init_idx_reg) + XW'(1);
    assign init_last   = (init_succ >= XW'(slot_cnt_reg));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_size_reg <= fbfl_pkg::BSIZE_RST;
            slot_cnt_reg <= fbfl_pkg::SLOT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                fbfl_pkg::REG_BSIZE:      blk_size_reg <= cfg_wdata;
                fbfl_pkg::REG_SLOT_COUNT: slot_cnt_reg <= cfg_wdata[CW-1:0];
                default:                  blk_size_reg <= blk_size_reg;
            endcase
        end
    end

    // link memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        link_rd_reg <= link_mem[head_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbfl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fbfl_pkg::S_EXEC;
                end
            end
            fbfl_pkg::S_EXEC:
            begin
                if (req_reg.func == fbfl_pkg::FUNC_INIT && !init_bad)
                begin
                    state_next = fbfl_pkg::S_INIT;
                end
                else if (out_free)
                begin
                    state_next = fbfl_pkg::S_IDLE;
                end
            end
            fbfl_pkg::S_INIT:
            begin
                if (links_done_reg)
                begin
                    state_next = fbfl_pkg::S_FIN;
                end
            end
            fbfl_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    state_next = fbfl_pkg::S_IDLE;
                end
            end
            default: state_next = fbfl_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        head_next       = head_reg;
        free_next       = free_reg;
        active_next     = active_reg;
        stride_next     = stride_reg;
        init_idx_next   = init_idx_reg;
        links_done_next = links_done_reg;
        div_dvd_next    = div_dvd_reg;
        div_q_next      = div_q_reg;
        mem_we          = 1'b0;
        mem_waddr       = init_idx_reg;
        mem_wdata       = NONE_SLOT;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        case (state_reg)
            fbfl_pkg::S_EXEC:
            begin
                case (req_reg.func)
                    fbfl_pkg::FUNC_INIT:
                    begin
                        if (init_bad)
                        begin
                            if (out_free)
                            begin
                                out_valid_next      = 1'b1;
                                out_next            = '0;
                                out_next.status     = fbfl_pkg::ST_INVALID;
                                out_next.free_slots = free_reg;
                            end
                        end
                        else
                        begin
                            init_idx_next   = '0;
                            links_done_next = 1'b0;
                            div_dvd_next    = SW'(stride_base) + SW'(ALIGN_BYTES - 1);
                        end
                    end
                    fbfl_pkg::FUNC_ALLOC:
                    begin
                        if (out_free)
                        begin
                            out_valid_next      = 1'b1;
                            out_next            = '0;
                            out_next.free_slots = free_reg;
                            if (list_empty)
                            begin
                                out_next.status = fbfl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                head_next = link_rd_reg;
                                if (free_reg != '0)
                                begin
                                    free_next = free_reg - CW'(1);
                                end
                                out_next.status       = fbfl_pkg::ST_OK;
                                out_next.granted_slot = head_reg[7:0];
                                out_next.byte_offset  = offset_prod[fbfl_pkg::OFFSET_W-1:0];
                                out_next.free_slots   = free_next;
                            end
                        end
                    end
                    fbfl_pkg::FUNC_FREE:
                    begin
                        if (out_free)
                        begin
                            out_valid_next      = 1'b1;
                            out_next            = '0;
                            if (free_bad)
                            begin
                                out_next.status = fbfl_pkg::ST_INVALID;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(req_reg.slot_index);
                                mem_wdata = head_reg;
                                head_next = LW'(req_reg.slot_index);
                                if (free_reg < active_reg)
                                begin
                                    free_next = free_reg + CW'(1);
                                end
                                out_next.status = fbfl_pkg::ST_OK;
                            end
                            out_next.free_slots = free_next;
                        end
                    end
                    fbfl_pkg::FUNC_RELEASE:
                    begin
                        if (out_free)
                        begin
                            head_next       = NONE_SLOT;
                            free_next       = '0;
                            active_next     = '0;
                            stride_next     = '0;
                            out_valid_next  = 1'b1;
                            out_next        = '0;
                            out_next.status = fbfl_pkg::ST_OK;
                        end
                    end
                    default: out_next = out_reg;
                endcase
            end
            fbfl_pkg::S_INIT:
            begin
                if (!links_done_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = init_idx_reg;
                    mem_wdata = init_last ? NONE_SLOT : LW'(init_succ);
                    if (init_last)
                    begin
                        links_done_next = 1'b1;
                    end
                    else
                    begin
                        init_idx_next = init_idx_reg + AW'(1);
                    end
                end
                // rounded-up number of alignment units per block, by reciprocal multiply
                div_q_next = div_prod[RS +: SW];
            end
            fbfl_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    stride_next         = stride_mult[SW-1:0];
                    active_next         = slot_cnt_reg;
                    head_next           = '0;
                    free_next           = slot_cnt_reg;
                    out_valid_next      = 1'b1;
                    out_next            = '0;
                    out_next.status     = fbfl_pkg::ST_OK;
                    out_next.free_slots = slot_cnt_reg;
                end
            end
            default: out_next = out_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fbfl_pkg::S_IDLE;
            out_valid_reg  <= 1'b0;
            head_reg       <= NONE_SLOT;
            free_reg       <= '0;
            active_reg     <= '0;
            stride_reg     <= '0;
            links_done_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            head_reg       <= head_next;
            free_reg       <= free_next;
            active_reg     <= active_next;
            stride_reg     <= stride_next;
            links_done_reg <= links_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
        out_reg      <= out_next;
        init_idx_reg <= init_idx_next;
        div_dvd_reg  <= div_dvd_next;
        div_q_reg    <= div_q_next;
    end

    a_free_le_active: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= active_reg)
        else $error("free count above active count");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == fbfl_pkg::S_EXEC)
        else $error("accepted beat not executed");

    a_grant_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fbfl_pkg::S_EXEC && req_reg.func == fbfl_pkg::FUNC_ALLOC &&
        out_free && !list_empty |-> XW'(head_reg) < XW'(active_reg))
        else $error("granted slot outside active pool");

    a_init_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fbfl_pkg::S_FIN |-> links_done_reg)
        else $error("init finished before links were ready");

endmodule

// ===== sim/fixed_block_free_list_allocator_tb.sv =====
// Testbench for fixed_block_free_list_allocator: random and directed init, alloc,
// free and release beats checked against a slot ledger that tracks the free list.
// Depends on fbfl_pkg and the allocator RTL.
module fixed_block_free_list_allocator_tb;

    localparam int NUM_SLOTS   = 256;
    localparam int ALIGN_BYTES = 16;
    localparam int LINK_BYTES  = 8;
    localparam int NONE_SLOT   = NUM_SLOTS;
    localparam int LIMIT_TIME  = 3000000;

    class slot_ledger;
        logic [fbfl_pkg::BSIZE_W-1:0]  blk_bytes;
        logic [fbfl_pkg::COUNT_W-1:0]  slot_count;
        logic [fbfl_pkg::COUNT_W-1:0]  link_mem [NUM_SLOTS];
        logic [fbfl_pkg::COUNT_W-1:0]  head;
        logic [fbfl_pkg::COUNT_W-1:0]  free_cnt;
        logic [fbfl_pkg::STRIDE_W-1:0] stride;
        logic [fbfl_pkg::COUNT_W-1:0]  active;
        fbfl_pkg::rsp_t                owed_rsp [$];
        logic [7:0]                    granted [$];
        int unsigned                   errors;

        function new();
            blk_bytes = fbfl_pkg::BSIZE_RST;
            slot_count = fbfl_pkg::SLOT_COUNT_RST;
            foreach (link_mem[i]) link_mem[i] = '0;
            head = fbfl_pkg::COUNT_W'(NONE_SLOT);
            free_cnt = '0;
            stride = '0;
            active = '0;
            errors = 0;
        endfunction

        function void write_reg(logic addr, logic [fbfl_pkg::CFG_DATA_W-1:0] data);
            if (addr == fbfl_pkg::REG_BSIZE)
                blk_bytes = data;
            else
                slot_count = data[fbfl_pkg::COUNT_W-1:0];
        endfunction

        function void take_request(fbfl_pkg::req_t r);
            fbfl_pkg::rsp_t               e;
            int unsigned                  s;
            int unsigned                  prod;
            logic [fbfl_pkg::COUNT_W-1:0] got;
            e = '0;
            case (r.func)
                fbfl_pkg::FUNC_INIT: begin
                    if (blk_bytes == 0 || slot_count == 0 || slot_count > NUM_SLOTS) begin
                        e.status = fbfl_pkg::ST_INVALID;
                    end else begin
                        s = (blk_bytes < LINK_BYTES) ? LINK_BYTES : blk_bytes;
                        s = ((s + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
                        stride = s[fbfl_pkg::STRIDE_W-1:0];
                        active = slot_count;
                        for (int i = 0; i < int'(slot_count); i++)
                            link_mem[i] = (i + 1 < int'(slot_count)) ?
                                          fbfl_pkg::COUNT_W'(i + 1) :
                                          fbfl_pkg::COUNT_W'(NONE_SLOT);
                        head = '0;
                        free_cnt = slot_count;
                        granted.delete();
                    end
                    e.free_slots = free_cnt;
                end
                fbfl_pkg::FUNC_ALLOC: begin
                    if (head >= NONE_SLOT) begin
                        e.status = fbfl_pkg::ST_EMPTY;
                    end else begin
                        got = head;
                        head = link_mem[got];
                        if (free_cnt > 0)
                            free_cnt = free_cnt - 1'b1;
                        prod = 32'(got) * 32'(stride);
                        e.granted_slot = got[7:0];
                        e.byte_offset = prod[fbfl_pkg::OFFSET_W-1:0];
                        granted.push_back(got[7:0]);
                    end
                    e.free_slots = free_cnt;
                end
                fbfl_pkg::FUNC_FREE: begin
                    if (r.slot_index >= active) begin
                        e.status = fbfl_pkg::ST_INVALID;
                    end else begin
                        link_mem[r.slot_index] = head;
                        head = fbfl_pkg::COUNT_W'(r.slot_index);
                        if (free_cnt < active)
                            free_cnt = free_cnt + 1'b1;
                        for (int i = 0; i < granted.size(); i++)
                            if (granted[i] == r.slot_index) begin
                                granted.delete(i);
                                break;
                            end
                    end
                    e.free_slots = free_cnt;
                end
                default: begin
                    head = fbfl_pkg::COUNT_W'(NONE_SLOT);
                    free_cnt = '0;
                    stride = '0;
                    active = '0;
                    granted.delete();
                end
            endcase
            owed_rsp.push_back(e);
        endfunction

        function void match_result(fbfl_pkg::rsp_t got);
            fbfl_pkg::rsp_t want;
            if (owed_rsp.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result beat with nothing pending: status=%0d slot=%0d",
                             got.status, got.granted_slot);
                return;
            end
            want = owed_rsp.pop_front();
            if (got.status !== want.status || got.granted_slot !== want.granted_slot ||
                got.byte_offset !== want.byte_offset || got.free_slots !== want.free_slots)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: want st=%0d slot=%0d off=%0h free=%0d, got %s",
                             want.status, want.granted_slot, want.byte_offset,
                             want.free_slots,
                             $sformatf("st=%0d slot=%0d off=%0h free=%0d", got.status,
                                       got.granted_slot, got.byte_offset, got.free_slots));
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    fbfl_pkg::req_t                  in_data;
    logic                            out_valid;
    logic                            out_ready;
    fbfl_pkg::rsp_t                  out_data;
    logic                            cfg_we;
    logic                            cfg_addr;
    logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_wdata;

    slot_ledger book = new();
    bit         quiet;

    fixed_block_free_list_allocator #(
        .NUM_SLOTS   (NUM_SLOTS),
        .ALIGN_BYTES (ALIGN_BYTES),
        .LINK_BYTES  (LINK_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    initial
    begin
        #(LIMIT_TIME);
        $display("simulation failed");
        $finish;
    end

    // result side: check every beat, then maybe stall
    initial
    begin
        int stall;
        out_ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                book.match_result(out_data);
                stall = quiet ? 0 : $urandom_range(0, 8);
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    task automatic go(fbfl_pkg::func_t f, logic [7:0] idx);
        fbfl_pkg::req_t r;
        int             gap;
        r.func = f;
        r.slot_index = idx;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do @(posedge clk); while (!in_ready);
        book.take_request(r);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (book.owed_rsp.size() != 0) @(posedge clk);
    endtask

    task automatic reconfigure(logic [fbfl_pkg::CFG_DATA_W-1:0] bs,
                               logic [fbfl_pkg::CFG_DATA_W-1:0] cnt);
        settle();
        cfg_we <= 1'b1;
        cfg_addr <= fbfl_pkg::REG_BSIZE;
        cfg_wdata <= bs;
        @(posedge clk);
        book.write_reg(fbfl_pkg::REG_BSIZE, bs);
        cfg_addr <= fbfl_pkg::REG_SLOT_COUNT;
        cfg_wdata <= cnt;
        @(posedge clk);
        book.write_reg(fbfl_pkg::REG_SLOT_COUNT, cnt);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int              alloc_w;
        int              roll;
        fbfl_pkg::func_t f;
        logic [7:0]      idx;
        logic [15:0]     bs;
        logic [15:0]     cnt;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_addr = fbfl_pkg::REG_BSIZE;
        cfg_wdata = '0;
        quiet = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pool, no pool, double free, re-init, bad configs
        go(fbfl_pkg::FUNC_ALLOC, 8'd0);
        go(fbfl_pkg::FUNC_FREE, 8'd0);
        go(fbfl_pkg::FUNC_RELEASE, 8'hFF);
        go(fbfl_pkg::FUNC_INIT, 8'd0);
        go(fbfl_pkg::FUNC_ALLOC, 8'd0);
        go(fbfl_pkg::FUNC_ALLOC, 8'd0);
        go(fbfl_pkg::FUNC_FREE, 8'd0);
        go(fbfl_pkg::FUNC_FREE, 8'd0);
        go(fbfl_pkg::FUNC_FREE, 8'd0);
        go(fbfl_pkg::FUNC_FREE, 8'd255);
        go(fbfl_pkg::FUNC_ALLOC, 8'd0);
        go(fbfl_pkg::FUNC_INIT, 8'd0);
        go(fbfl_pkg::FUNC_RELEASE, 8'd0);
        reconfigure(16'd0, 16'd256);
        go(fbfl_pkg::FUNC_INIT, 8'd0);
        reconfigure(16'hFFFF, 16'd0);
        go(fbfl_pkg::FUNC_INIT, 8'd0);
        reconfigure(16'hFFFF, 16'd257);
        go(fbfl_pkg::FUNC_INIT, 8'd0);
        reconfigure(16'hFFFF, 16'd256);
        go(fbfl_pkg::FUNC_INIT, 8'd0);
        go(fbfl_pkg::FUNC_FREE, 8'd255);
        go(fbfl_pkg::FUNC_ALLOC, 8'd0);
        reconfigure(16'd1, 16'd1);
        go(fbfl_pkg::FUNC_INIT, 8'd0);
        go(fbfl_pkg::FUNC_ALLOC, 8'd0);
        go(fbfl_pkg::FUNC_ALLOC, 8'd0);
        go(fbfl_pkg::FUNC_FREE, 8'd1);
        go(fbfl_pkg::FUNC_FREE, 8'd0);
        go(fbfl_pkg::FUNC_RELEASE, 8'd0);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin bs = 16'd1;     cnt = 16'd256; end
                1: begin bs = 16'hFFFF;  cnt = 16'd256; end
                2: begin bs = 16'd16;    cnt = 16'd1;   end
                3: begin bs = 16'd9;     cnt = 16'd2;   end
                7: begin
                    bs = 16'($urandom_range(0, 65535));
                    cnt = 16'($urandom_range(0, 511));
                end
                default: begin
                    bs = 16'($urandom_range(1, 65535));
                    cnt = 16'($urandom_range(1, 256));
                end
            endcase
            reconfigure(bs, cnt);
            quiet = (ph % 3 == 2);
            alloc_w = $urandom_range(30, 65);
            go(fbfl_pkg::FUNC_INIT, 8'($urandom_range(0, 255)));
            for (int k = 1; k < 135; k++)
            begin
                roll = $urandom_range(0, 99);
                idx = 8'($urandom_range(0, 255));
                if (roll < 3)
                    f = fbfl_pkg::FUNC_INIT;
                else if (roll < 5)
                    f = fbfl_pkg::FUNC_RELEASE;
                else if (roll < 5 + alloc_w)
                    f = fbfl_pkg::FUNC_ALLOC;
                else begin
                    f = fbfl_pkg::FUNC_FREE;
                    if (book.granted.size() > 0 && $urandom_range(0, 99) < 85)
                        idx = book.granted[$urandom_range(0, book.granted.size() - 1)];
                end
                go(f, idx);
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (book.errors == 0 && book.owed_rsp.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
